FILE: rtl/spa_pkg.sv
package spa_pkg;

   localparam int COEF_W = 32;
   localparam int EXP_W  = 16;

   // request action codes
   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_MERGE  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_MERGE = 2'b10
   } spa_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic merge_init;
      logic merge_step;
      logic merge_finish;
   } spa_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;   // both list heads exhausted
   } spa_status_type;

endpackage

FILE: rtl/sparse_polynomial_add.sv
// Sparse polynomial adder: merges two term lists (A and B), each held in
// descending exponent order, and streams out their sum.
// Request channel: a request is taken on a rising edge with start high and
//   busy low. req_action selects load into A, load into B, merge, or
//   nothing (unused code). Busy stays low during a load, so loads can be
//   issued every cycle. A load into a full list (DEPTH terms)
//   is dropped and flags the run as truncated.
// Merge: busy is high through the merge steps (one head comparison each;
//   at most count_a + count_b steps) and a closing step. Each list has
//   a single read port addressed by its head index, so one step per cycle.
// Result channel: rsp_strobe marks each result for exactly one cycle, there
//   is no back-pressure. Each result waits in a one-term holding register
//   (so that last can be marked) until the next term is produced or the
//   merge closes, then goes out through the output registers. Equal
//   exponents are summed, zero sums dropped, wrapped sums flagged in
//   rsp_overflow. An empty sum gives one result with rsp_term_valid low.
//   rsp_last marks the final result; both lists are then cleared.
// Reset: synchronous, active high; empties both lists and clears the
//   truncated flag and any merge in progress.
module sparse_polynomial_add import spa_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_action,
   input  logic signed [COEF_W-1:0] req_coef,
   input  logic [EXP_W-1:0]         req_exponent,
   output logic                     rsp_strobe,
   output logic signed [COEF_W-1:0] rsp_coef_res,
   output logic [EXP_W-1:0]         rsp_exponent_res,
   output logic                     rsp_term_valid,
   output logic                     rsp_last,
   output logic                     rsp_overflow,
   output logic                     rsp_truncated
);

   spa_cmd_type    cmd;
   spa_status_type status;

   // sequencer: decodes requests, runs the merge loop
   spa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .status     (status),
      .busy       (busy),
      .cmd        (cmd)
   );

   // term lists, head comparator/adder and result registers
   spa_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .in_coef        (req_coef),
      .in_exp         (req_exponent),
      .status         (status),
      .out_strobe     (rsp_strobe),
      .out_coef       (rsp_coef_res),
      .out_exp        (rsp_exponent_res),
      .out_term_valid (rsp_term_valid),
      .out_last       (rsp_last),
      .out_overflow   (rsp_overflow),
      .out_truncated  (rsp_truncated)
   );

   // end of a merge always shows a final result on the same edge
   a_busy_end_last : assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> (rsp_strobe && rsp_last))
      else $error("merge ended without a final result");

   // the final result of a run is never followed directly by another
   a_last_gap : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result straight after final result");

   // an empty result is only the lone closing result, with zero coefficient and no overflow
   a_empty_sum : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_term_valid) |->
         (rsp_last && (rsp_coef_res == '0) && !rsp_overflow))
      else $error("malformed empty result");

endmodule

FILE: rtl/spa_ctrl.sv
module spa_ctrl import spa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [1:0]     req_action,
   input  spa_status_type status,
   output logic           busy,
   output spa_cmd_type    cmd
);

   spa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_action)
                  ACT_LOAD_A: cmd.load_a = 1'b1;
                  ACT_LOAD_B: cmd.load_b = 1'b1;
                  ACT_MERGE: begin
                     cmd.merge_init = 1'b1;
                     state_in       = ST_MERGE;
                  end
                  default: ;   // unused action: no effect
               endcase
            end
         end
         ST_MERGE: begin
            if (status.done) begin
               cmd.merge_finish = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.merge_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff == ST_MERGE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/spa_dpath.sv
module spa_dpath import spa_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spa_cmd_type              cmd,
   input  logic signed [COEF_W-1:0] in_coef,
   input  logic [EXP_W-1:0]         in_exp,
   output spa_status_type           status,
   output logic                     out_strobe,
   output logic signed [COEF_W-1:0] out_coef,
   output logic [EXP_W-1:0]         out_exp,
   output logic                     out_term_valid,
   output logic                     out_last,
   output logic                     out_overflow,
   output logic                     out_truncated
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [COEF_W-1:0] a_coef_ff [DEPTH];
   logic [COEF_W-1:0] a_coef_in [DEPTH];
   logic [EXP_W-1:0]  a_exp_ff  [DEPTH];
   logic [EXP_W-1:0]  a_exp_in  [DEPTH];
   logic [COEF_W-1:0] b_coef_ff [DEPTH];
   logic [COEF_W-1:0] b_coef_in [DEPTH];
   logic [EXP_W-1:0]  b_exp_ff  [DEPTH];
   logic [EXP_W-1:0]  b_exp_in  [DEPTH];

   logic [CW-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CW-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;
   logic          lost_ff, lost_in;

   // one-term holding register: a term goes out only once its successor
   // (or the end of the run) is known, so that last can be marked
   logic              pend_valid_ff, pend_valid_in;
   logic [COEF_W-1:0] pend_coef_ff, pend_coef_in;
   logic [EXP_W-1:0]  pend_exp_ff, pend_exp_in;
   logic              pend_ovf_ff, pend_ovf_in;

   logic              strobe_ff, strobe_in;
   logic [COEF_W-1:0] ocoef_ff, ocoef_in;
   logic [EXP_W-1:0]  oexp_ff, oexp_in;
   logic              otv_ff, otv_in;
   logic              olast_ff, olast_in;
   logic              oovf_ff, oovf_in;
   logic              otrunc_ff, otrunc_in;

   logic              a_has, b_has, take_a, take_b, take_both, produce;
   logic [COEF_W-1:0] ca, cb, sum, cand_coef;
   logic [EXP_W-1:0]  ea, eb, cand_exp;
   logic              sum_ovf;

   // head comparison
   always_comb begin
      a_has     = (idx_a_ff < cnt_a_ff);
      b_has     = (idx_b_ff < cnt_b_ff);
      ca        = a_coef_ff[idx_a_ff[AW-1:0]];
      ea        = a_exp_ff[idx_a_ff[AW-1:0]];
      cb        = b_coef_ff[idx_b_ff[AW-1:0]];
      eb        = b_exp_ff[idx_b_ff[AW-1:0]];
      take_a    = a_has && (!b_has || (ea > eb));
      take_b    = b_has && (!a_has || (eb > ea));
      take_both = a_has && b_has && (ea == eb);
      sum       = ca + cb;
      sum_ovf   = (~(ca[COEF_W-1] ^ cb[COEF_W-1])) & (ca[COEF_W-1] ^ sum[COEF_W-1]);
      cand_coef = take_a ? ca : (take_b ? cb : sum);
      cand_exp  = take_b ? eb : ea;
      produce   = take_a || take_b || (take_both && ((sum != '0) || sum_ovf));
      status.done = !a_has && !b_has;
   end

   always_comb begin
      a_coef_in     = a_coef_ff;
      a_exp_in      = a_exp_ff;
      b_coef_in     = b_coef_ff;
      b_exp_in      = b_exp_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      idx_a_in      = idx_a_ff;
      idx_b_in      = idx_b_ff;
      lost_in       = lost_ff;
      pend_valid_in = pend_valid_ff;
      pend_coef_in  = pend_coef_ff;
      pend_exp_in   = pend_exp_ff;
      pend_ovf_in   = pend_ovf_ff;
      strobe_in     = 1'b0;
      ocoef_in      = ocoef_ff;
      oexp_in       = oexp_ff;
      otv_in        = otv_ff;
      olast_in      = olast_ff;
      oovf_in       = oovf_ff;
      otrunc_in     = otrunc_ff;

      if (cmd.load_a) begin
         if (cnt_a_ff == CW'(DEPTH)) begin
            lost_in = 1'b1;
         end else begin
            a_coef_in[cnt_a_ff[AW-1:0]] = in_coef;
            a_exp_in[cnt_a_ff[AW-1:0]]  = in_exp;
            cnt_a_in                    = cnt_a_ff + CW'(1);
         end
      end

      if (cmd.load_b) begin
         if (cnt_b_ff == CW'(DEPTH)) begin
            lost_in = 1'b1;
         end else begin
            b_coef_in[cnt_b_ff[AW-1:0]] = in_coef;
            b_exp_in[cnt_b_ff[AW-1:0]]  = in_exp;
            cnt_b_in                    = cnt_b_ff + CW'(1);
         end
      end

      if (cmd.merge_init) begin
         idx_a_in      = '0;
         idx_b_in      = '0;
         pend_valid_in = 1'b0;
      end

      if (cmd.merge_step) begin
         if (take_a || take_both) idx_a_in = idx_a_ff + CW'(1);
         if (take_b || take_both) idx_b_in = idx_b_ff + CW'(1);
         if (produce) begin
            if (pend_valid_ff) begin
               strobe_in = 1'b1;
               ocoef_in  = pend_coef_ff;
               oexp_in   = pend_exp_ff;
               otv_in    = 1'b1;
               olast_in  = 1'b0;
               oovf_in   = pend_ovf_ff;
               otrunc_in = lost_ff;
            end
            pend_valid_in = 1'b1;
            pend_coef_in  = cand_coef;
            pend_exp_in   = cand_exp;
            pend_ovf_in   = take_both & sum_ovf;
         end
      end

      if (cmd.merge_finish) begin
         strobe_in = 1'b1;
         olast_in  = 1'b1;
         otrunc_in = lost_ff;
         if (pend_valid_ff) begin
            ocoef_in = pend_coef_ff;
            oexp_in  = pend_exp_ff;
            otv_in   = 1'b1;
            oovf_in  = pend_ovf_ff;
         end else begin
            // empty sum
            ocoef_in = '0;
            oexp_in  = '0;
            otv_in   = 1'b0;
            oovf_in  = 1'b0;
         end
         pend_valid_in = 1'b0;
         cnt_a_in      = '0;
         cnt_b_in      = '0;
         lost_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         idx_a_ff      <= '0;
         idx_b_ff      <= '0;
         lost_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         idx_a_ff      <= idx_a_in;
         idx_b_ff      <= idx_b_in;
         lost_ff       <= lost_in;
         pend_valid_ff <= pend_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      a_coef_ff    <= a_coef_in;
      a_exp_ff     <= a_exp_in;
      b_coef_ff    <= b_coef_in;
      b_exp_ff     <= b_exp_in;
      pend_coef_ff <= pend_coef_in;
      pend_exp_ff  <= pend_exp_in;
      pend_ovf_ff  <= pend_ovf_in;
      ocoef_ff     <= ocoef_in;
      oexp_ff      <= oexp_in;
      otv_ff       <= otv_in;
      olast_ff     <= olast_in;
      oovf_ff      <= oovf_in;
      otrunc_ff    <= otrunc_in;
   end

   assign out_strobe     = strobe_ff;
   assign out_coef       = ocoef_ff;
   assign out_exp        = oexp_ff;
   assign out_term_valid = otv_ff;
   assign out_last       = olast_ff;
   assign out_overflow   = oovf_ff;
   assign out_truncated  = otrunc_ff;

endmodule
